>>> hdl/rf3_pkg.sv
`default_nettype none

package rf3_pkg;

   localparam int WINDOW_SIZE = 3;
   localparam int WIN_N       = WINDOW_SIZE * WINDOW_SIZE;
   localparam int PIX_W       = 8;
   localparam int MODE_W      = 2;

   typedef logic [PIX_W-1:0]  pix_type;
   typedef pix_type [WIN_N-1:0] win_type;
   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_MIN   = 2'd0;
   localparam mode_type MODE_MED   = 2'd1;
   localparam mode_type MODE_MAX   = 2'd2;
   localparam mode_type MODE_RESET = MODE_MED;

endpackage

`default_nettype wire

>>> hdl/rf3_rank.sv
`default_nettype none

module rf3_rank (
   input  wire rf3_pkg::win_type  win,
   input  wire                    is_border,
   input  wire rf3_pkg::mode_type rank_mode,
   output rf3_pkg::pix_type       filtered_pixel
);

   typedef struct packed {
      rf3_pkg::pix_type hi;
      rf3_pkg::pix_type mid;
      rf3_pkg::pix_type lo;
   } trio_type;

   function automatic rf3_pkg::pix_type min2(input rf3_pkg::pix_type a,
                                             input rf3_pkg::pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic rf3_pkg::pix_type max2(input rf3_pkg::pix_type a,
                                             input rf3_pkg::pix_type b);
      return (a < b) ? b : a;
   endfunction

   // Three-input sorting network: three compare-exchange steps.
   function automatic trio_type sort3(input rf3_pkg::pix_type a,
                                      input rf3_pkg::pix_type b,
                                      input rf3_pkg::pix_type c);
      rf3_pkg::pix_type l1;
      rf3_pkg::pix_type h1;
      rf3_pkg::pix_type h2;
      trio_type         r;
      l1    = min2(a, b);
      h1    = max2(a, b);
      h2    = max2(h1, c);
      r.hi  = h2;
      r.lo  = min2(l1, min2(h1, c));
      r.mid = max2(l1, min2(h1, c));
      return r;
   endfunction

   trio_type row0;
   trio_type row1;
   trio_type row2;
   trio_type col_mid;
   trio_type med_trio;
   rf3_pkg::pix_type lo_max;
   rf3_pkg::pix_type hi_min;
   rf3_pkg::pix_type win_min;
   rf3_pkg::pix_type win_max;
   rf3_pkg::pix_type win_med;

   // Sort each row, then the median is the median of the largest row minimum,
   // the median of the row medians and the smallest row maximum.
   always_comb begin
      row0     = sort3(win[0], win[1], win[2]);
      row1     = sort3(win[3], win[4], win[5]);
      row2     = sort3(win[6], win[7], win[8]);
      lo_max   = max2(row0.lo, max2(row1.lo, row2.lo));
      hi_min   = min2(row0.hi, min2(row1.hi, row2.hi));
      col_mid  = sort3(row0.mid, row1.mid, row2.mid);
      med_trio = sort3(lo_max, col_mid.mid, hi_min);
      win_med  = med_trio.mid;
      win_min  = min2(row0.lo, min2(row1.lo, row2.lo));
      win_max  = max2(row0.hi, max2(row1.hi, row2.hi));
   end

   always_comb begin
      if (is_border) begin
         filtered_pixel = win[rf3_pkg::WIN_N / 2];
      end else begin
         case (rank_mode)
            rf3_pkg::MODE_MIN: filtered_pixel = win_min;
            rf3_pkg::MODE_MAX: filtered_pixel = win_max;
            default:           filtered_pixel = win_med;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hdl/rank_filter_3x3.sv
// Channel  Direction  Payload
// req_     in         tdata: win_0 .. win_8, 8 bits each; tuser: is_border
// rsp_     out        tdata: filtered_pixel
// csr_     in         data: rank_mode
//
// One window is accepted per clock while rsp_tready does not stall; each window
// goes through two register stages, one for the window and one for the result.
// The rank logic between the two registers is a fixed sorting network.
// Synchronous active-high reset empties both stages and sets the median mode.
// A stall on rsp_tready holds the result register and backs up into the
// window register before req_tready drops.
`default_nettype none

module rank_filter_3x3 (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   // win_0 [7:0], win_1 [15:8], ... win_8 [71:64]
   input  wire [rf3_pkg::WIN_N*rf3_pkg::PIX_W-1:0] req_tdata,
   // is_border [0]
   input  wire                         req_tuser,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   // filtered_pixel [7:0]
   output logic [rf3_pkg::PIX_W-1:0]   rsp_tdata,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [rf3_pkg::MODE_W-1:0]  csr_data
);

   rf3_pkg::mode_type mode_ff;
   logic              win_valid_ff;
   rf3_pkg::win_type  win_ff;
   logic              border_ff;
   logic              rsp_valid_ff;
   rf3_pkg::pix_type  rsp_pixel_ff;
   rf3_pkg::pix_type  rsp_pixel_in;
   logic              rsp_load;
   logic              win_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rf3_pkg::MODE_RESET;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   // The result register takes a new value whenever it is empty or drained.
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign win_load   = !win_valid_ff || rsp_load;
   assign req_tready = win_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
      end else if (win_load) begin
         win_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (win_load && req_tvalid) begin
         win_ff    <= rf3_pkg::win_type'(req_tdata);
         border_ff <= req_tuser;
      end
   end

   rf3_rank u_rank (
      .win            (win_ff),
      .is_border      (border_ff),
      .rank_mode      (mode_ff),
      .filtered_pixel (rsp_pixel_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= win_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && win_valid_ff) begin
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;

endmodule

`default_nettype wire
